// File: hw/rtl/rdgt_pkg.sv
// Package for the ranged download gap tracker: codes, types and constants.
package rdgt_pkg;

  localparam int unsigned OffW   = 32;
  localparam int unsigned LenW   = 16;
  localparam int unsigned LogW   = 16;
  localparam logic [31:0] TailEnd = 32'h0FFF_FFFF;
  localparam logic [15:0] ProblemTruncated = 16'd3;
  localparam logic [15:0] ProblemInvalid   = 16'd5;

  typedef enum logic [2:0] {
    FuncStart = 3'd0,
    FuncCancel = 3'd1,
    FuncFrame = 3'd2,
    FuncDiag = 3'd3,
    FuncTick = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    KindRange = 2'd0,
    KindOk = 2'd1,
    KindError = 2'd2,
    KindStop = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeLoad = 2'd1,
    ModeError = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CfgIdleTimeout = 2'd0,
    CfgMaxStalled = 2'd1,
    CfgMaxRanges = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StInsScan,
    StInsShift,
    StInsWrite,
    StRetRead,
    StRetShift,
    StTickEval,
    StGapRead,
    StGapStep,
    StTail,
    StFlush
  } state_e;

endpackage

// File: hw/rtl/ranged_download_gap_tracker_core.sv
// Top level of the ranged download gap tracker: sequencer and held-frame table.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-----------------------
//  event in | func_i log_id_i frame_offset_i ...           | start_i && !busy_o
//  result   | kind_o out_log_id_o range_* last_of_run_o ...| valid_o, one cycle
//  config   | cfg_we_i cfg_idx_i cfg_data_i                | cfg_we_i, no wait
//
// Start, cancel, diagnostic end in idle; a stop result shows the cycle after.
// A frame walks the table one entry a cycle to find its slot, then shifts the
// tail up one entry a cycle. Each entry it retires at the frontier costs a
// further shift pass over the held entries. A tick that opens a round walks
// the held entries with a read and a step state each, then a tail state and a
// flush state that pushes out the last range. The single table read port sets
// the pace of these walks.
// Reset clears the valid count; table contents need no reset.
// Results cannot be stalled; each is shown for one cycle with valid_o.
module ranged_download_gap_tracker_core #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned RANGE_LIMIT = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  logic [2:0] func_i,
  input  logic [15:0] log_id_i,
  input  logic [31:0] frame_offset_i,
  input  logic [15:0] frame_length_i,
  input  logic [15:0] problem_code_i,
  input  logic [31:0] reported_size_i,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output logic valid_o,
  output logic [1:0] kind_o,
  output logic [15:0] out_log_id_o,
  output logic [31:0] range_start_o,
  output logic [31:0] range_end_o,
  output logic last_of_run_o,
  output logic [31:0] received_frontier_o
);
  import rdgt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned LimW = $clog2(RANGE_LIMIT + 1);

  // table memory, one read and one write port
  logic [47:0] mem_q [TABLE_ENTRIES];
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic [47:0] wr_data, rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end
  wire [31:0] rd_off = rd_q[47:16];
  wire [15:0] rd_len = rd_q[15:0];

  state_e state_q, state_d;
  logic [CntW-1:0] n_q, n_d;        // valid entries form a prefix
  logic [CntW-1:0] i_q, i_d;        // walk index
  logic [CntW-1:0] pos_q, pos_d;
  logic [LimW-1:0] k_q, k_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] off_q, off_d;
  logic [15:0] len_q, len_d;
  logic [31:0] frontier_q, frontier_d, highest_q, highest_d, fsize_q, fsize_d;
  logic [31:0] frames_q, frames_d, car_q, car_d, tick_q, tick_d, rtick_q, rtick_d;
  logic eof_q, eof_d, pend_q, pend_d, rfin_q, rfin_d;
  logic [4:0] rexp_q, rexp_d, rans_q, rans_d;
  logic [7:0] stall_q, stall_d;
  logic [15:0] log_q, log_d;
  mode_e mode_q, mode_d;
  logic [7:0] cfg_to_q, cfg_ms_q;
  logic [4:0] cfg_mr_q;

  logic o_valid_d, o_last_d;
  kind_e o_kind_d;
  logic [31:0] o_s_d, o_e_d;
  logic [LimW-1:0] limit;

  always_comb begin
    if (cfg_mr_q == '0) limit = LimW'(1);
    else if (32'(cfg_mr_q) > RANGE_LIMIT) limit = LimW'(RANGE_LIMIT);
    else limit = LimW'(cfg_mr_q);
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_to_q <= 8'd10;
      cfg_ms_q <= 8'd8;
      cfg_mr_q <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdleTimeout: cfg_to_q <= cfg_data_i;
        CfgMaxStalled: cfg_ms_q <= cfg_data_i;
        CfgMaxRanges: cfg_mr_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [31:0] now_w;
  logic idle_w, contig_w, prog_w;
  logic [7:0] stall_inc;

  always_comb begin
    state_d = state_q; n_d = n_q; i_d = i_q; pos_d = pos_q; k_d = k_q; cur_d = cur_q;
    off_d = off_q; len_d = len_q; frontier_d = frontier_q; highest_d = highest_q;
    fsize_d = fsize_q; frames_d = frames_q; car_d = car_q; tick_d = tick_q;
    rtick_d = rtick_q; eof_d = eof_q; pend_d = pend_q; rfin_d = rfin_q;
    rexp_d = rexp_q; rans_d = rans_q; stall_d = stall_q; log_d = log_q; mode_d = mode_q;
    o_valid_d = 1'b0; o_last_d = 1'b0; o_kind_d = KindRange; o_s_d = '0; o_e_d = '0;
    rd_addr = i_q[IdxW-1:0]; wr_addr = '0; wr_en = 1'b0; wr_data = '0;
    now_w = tick_q;
    idle_w = (now_w - rtick_q) >= 32'(cfg_to_q);
    contig_w = (frontier_q == highest_q);
    prog_w = !pend_q || (frames_q != car_q);
    stall_inc = (stall_q == 8'hFF) ? stall_q : stall_q + 8'd1;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          unique case (func_i)
            FuncStart, FuncCancel: begin
              if (func_i == FuncStart || log_id_i == log_q) begin
                if (mode_q == ModeLoad && (func_i == FuncCancel || log_q != log_id_i)) begin
                  o_valid_d = 1'b1; o_last_d = 1'b1; o_kind_d = KindStop;
                end
                n_d = '0; frontier_d = '0; highest_d = '0; fsize_d = '0;
                frames_d = '0; car_d = '1; eof_d = 1'b0; pend_d = 1'b0;
                rfin_d = 1'b0; rexp_d = '0; rans_d = '0; stall_d = '0; rtick_d = '0;
                if (func_i == FuncStart) begin
                  log_d = log_id_i; mode_d = ModeLoad;
                end else begin
                  mode_d = ModeIdle;
                end
              end
            end
            FuncFrame: begin
              if (mode_q == ModeLoad && log_id_i == log_q && frame_length_i != '0
                  && frame_offset_i >= frontier_q) begin
                off_d = frame_offset_i; len_d = frame_length_i;
                i_d = '0; rd_addr = '0; state_d = StInsScan;
              end
            end
            FuncDiag: begin
              if (mode_q == ModeLoad && log_id_i == log_q) begin
                if (reported_size_i != '0) fsize_d = reported_size_i;
                if (problem_code_i == ProblemTruncated || problem_code_i == ProblemInvalid)
                  eof_d = 1'b1;
                rans_d = (rans_q < 5'd31) ? rans_q + 5'd1 : rans_q;
                if (rans_d >= rexp_q) rfin_d = 1'b1;
              end
            end
            FuncTick: begin
              tick_d = tick_q + 32'd1;
              if (mode_q == ModeLoad) state_d = StTickEval;
            end
            default: ;
          endcase
        end
      end
      // walk until the first entry not below the new offset
      StInsScan: begin
        if (i_q >= n_q) begin
          if (n_q >= CntW'(TABLE_ENTRIES)) state_d = StIdle;
          else begin
            pos_d = i_q; i_d = n_q; state_d = StInsShift;
            rd_addr = IdxW'(n_q - CntW'(1));
          end
        end else if (rd_off == off_q) state_d = StIdle;
        else if (rd_off > off_q) begin
          if (n_q >= CntW'(TABLE_ENTRIES)) state_d = StIdle;
          else begin
            pos_d = i_q; i_d = n_q; state_d = StInsShift;
            rd_addr = IdxW'(n_q - CntW'(1));
          end
        end else begin
          i_d = i_q + CntW'(1); rd_addr = IdxW'(i_d);
        end
      end
      // move entries up one slot, from the top down to pos
      StInsShift: begin
        if (i_q == pos_q) begin
          state_d = StInsWrite;
        end else begin
          wr_en = 1'b1; wr_addr = IdxW'(i_q); wr_data = rd_q;
          i_d = i_q - CntW'(1);
          rd_addr = IdxW'(i_d - CntW'(1));
        end
      end
      StInsWrite: begin
        wr_en = 1'b1; wr_addr = IdxW'(pos_q); wr_data = {off_q, len_q};
        if (pos_q == n_q) highest_d = off_q + 32'(len_q);
        n_d = n_q + CntW'(1);
        if (frames_q != '1) frames_d = frames_q + 32'd1;
        // retire pass only if the head can reach the frontier
        if (pos_q == '0 && off_q <= frontier_q) begin
          if (off_q == frontier_q) frontier_d = frontier_q + 32'(len_q);
          i_d = '0; rd_addr = IdxW'(1); state_d = StRetShift;
        end else state_d = StIdle;
      end
      StRetRead: begin
        if (n_q != '0 && rd_off <= frontier_q) begin
          if (rd_off == frontier_q) frontier_d = frontier_q + 32'(rd_len);
          i_d = '0; rd_addr = IdxW'(1); state_d = StRetShift;
        end else state_d = StIdle;
      end
      // drop the head: entry i takes entry i+1
      StRetShift: begin
        if (i_q + CntW'(1) >= n_q) begin
          n_d = n_q - CntW'(1); rd_addr = '0; state_d = StRetRead;
        end else begin
          wr_en = 1'b1; wr_addr = IdxW'(i_q); wr_data = rd_q;
          i_d = i_q + CntW'(1); rd_addr = IdxW'(i_d + CntW'(1));
        end
      end
      StTickEval: begin
        state_d = StIdle;
        if (!(pend_q && !rfin_q && !idle_w)) begin
          if ((eof_q && contig_w && pend_q && !prog_w) ||
              (fsize_q != '0 && frontier_q >= fsize_q && contig_w)) begin
            pend_d = 1'b0; mode_d = ModeIdle;
            o_valid_d = 1'b1; o_last_d = 1'b1; o_kind_d = KindOk;
          end else if (pend_q && !prog_w && stall_inc >= cfg_ms_q) begin
            stall_d = stall_inc; pend_d = 1'b0;
            mode_d = (eof_q && contig_w) ? ModeIdle : ModeError;
            o_valid_d = 1'b1; o_last_d = 1'b1;
            o_kind_d = (eof_q && contig_w) ? KindOk : KindError;
          end else begin
            stall_d = (pend_q && !prog_w) ? stall_inc : 8'd0;
            i_d = '0; k_d = '0; cur_d = frontier_q; rd_addr = '0; state_d = StGapRead;
          end
        end
      end
      StGapRead: begin
        // wait here for the registered read data of entry i to settle
        state_d = (i_q < n_q && k_q < limit) ? StGapStep : StTail;
      end
      StGapStep: begin
        if (rd_off >= cur_q) begin
          if (rd_off > cur_q) begin
            o_valid_d = 1'b1; o_kind_d = KindRange; o_s_d = cur_q;
            o_e_d = rd_off + 32'(rd_len); k_d = k_q + LimW'(1);
          end
          cur_d = rd_off + 32'(rd_len);
        end
        i_d = i_q + CntW'(1); rd_addr = IdxW'(i_d);
        state_d = StGapRead;
      end
      StTail: begin
        state_d = StIdle;
        if (k_q < limit && (fsize_q == '0 || cur_q < fsize_q)) begin
          // the tail goes into the hold register like any other range
          o_valid_d = 1'b1; o_kind_d = KindRange; o_s_d = cur_q; o_e_d = TailEnd;
          k_d = k_q + LimW'(1);
        end
        if (k_d == '0) begin
          pend_d = 1'b0; mode_d = contig_w ? ModeIdle : ModeError;
          o_valid_d = 1'b1; o_last_d = 1'b1; o_kind_d = contig_w ? KindOk : KindError;
        end else begin
          car_d = frames_q; rans_d = '0; rexp_d = 5'(k_d); rfin_d = 1'b0;
          rtick_d = tick_q; pend_d = 1'b1;
          state_d = StFlush;
        end
      end
      // push out the held range as the last of the round
      StFlush: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // ranges are emitted before the round's last is known: hold one back
  logic hold_v_q;
  logic [31:0] hold_s_q, hold_e_q;
  logic [1:0] out_kind_q;
  logic out_v_q, out_last_q;
  logic [31:0] out_s_q, out_e_q, out_f_q;
  logic [15:0] out_log_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; n_q <= '0; mode_q <= ModeIdle; frontier_q <= '0;
      highest_q <= '0; fsize_q <= '0; frames_q <= '0; car_q <= '1; tick_q <= '0;
      rtick_q <= '0; eof_q <= 1'b0; pend_q <= 1'b0; rfin_q <= 1'b0; rexp_q <= '0;
      rans_q <= '0; stall_q <= '0; log_q <= '0; hold_v_q <= 1'b0; out_v_q <= 1'b0;
      i_q <= '0; pos_q <= '0; k_q <= '0;
    end else begin
      state_q <= state_d; n_q <= n_d; mode_q <= mode_d; frontier_q <= frontier_d;
      highest_q <= highest_d; fsize_q <= fsize_d; frames_q <= frames_d; car_q <= car_d;
      tick_q <= tick_d; rtick_q <= rtick_d; eof_q <= eof_d; pend_q <= pend_d;
      rfin_q <= rfin_d; rexp_q <= rexp_d; rans_q <= rans_d; stall_q <= stall_d;
      log_q <= log_d; i_q <= i_d; pos_q <= pos_d; k_q <= k_d;
      if (o_valid_d && o_kind_d == KindRange && !o_last_d) begin
        // flush the held range, keep the new one
        out_v_q <= hold_v_q;
        hold_v_q <= 1'b1;
      end else if (o_valid_d) begin
        out_v_q <= 1'b1;
        hold_v_q <= 1'b0;
      end else if (state_q == StFlush && hold_v_q) begin
        out_v_q <= 1'b1; hold_v_q <= 1'b0;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; off_q <= off_d; len_q <= len_d;
    out_log_q <= log_q;
    out_f_q <= frontier_q;
    if (o_valid_d && o_kind_d == KindRange && !o_last_d) begin
      hold_s_q <= o_s_d; hold_e_q <= o_e_d;
      out_kind_q <= KindRange; out_last_q <= 1'b0; out_s_q <= hold_s_q; out_e_q <= hold_e_q;
    end else if (o_valid_d) begin
      out_kind_q <= o_kind_d; out_last_q <= 1'b1; out_s_q <= o_s_d; out_e_q <= o_e_d;
    end else begin
      out_kind_q <= KindRange; out_last_q <= 1'b1; out_s_q <= hold_s_q; out_e_q <= hold_e_q;
    end
  end

  assign valid_o = out_v_q;
  assign kind_o = out_kind_q;
  assign out_log_id_o = out_log_q;
  assign range_start_o = out_s_q;
  assign range_end_o = out_e_q;
  assign last_of_run_o = out_last_q;
  assign received_frontier_o = out_f_q;

  // table never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= CntW'(TABLE_ENTRIES))
    else $error("held count overflow");
  // no event accepted while sequencer runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> busy_o) else $error("busy dropped");
  // frontier holds its value across each retire shift step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRetShift) |=> $stable(frontier_q)) else $error("frontier moved in shift");
  // a tick taken in load mode always leaves idle for evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && start_i && func_i == FuncTick && mode_q == ModeLoad)
    |=> state_q == StTickEval) else $error("tick not evaluated");
endmodule

// File: sim/ranged_download_gap_tracker_core_tb.sv
// Self-checking testbench for the ranged download gap tracker core.
`timescale 1ns / 1ps

module ranged_download_gap_tracker_core_tb;
  import rdgt_pkg::*;

  localparam int unsigned Entries   = 64;
  localparam int unsigned MaxRanges = 16;
  // Quiet cycles once the block is idle and owes nothing.
  localparam int unsigned SettleCycles = 2 * Entries + 100;
  // Worst item: a frame that retires a full table one shift pass per entry.
  localparam int unsigned WorstItemCycles = Entries * (Entries + 3) / 2 + 2 * Entries + 60;
  localparam int unsigned CycleLimit   = 4 * 640 * WorstItemCycles;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] log_id;
    logic [31:0] rstart;
    logic [31:0] rend;
    logic        last;
    logic [31:0] frontier;
  } gap_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  func_i;
  logic [15:0] log_id_i;
  logic [31:0] frame_offset_i;
  logic [15:0] frame_length_i;
  logic [15:0] problem_code_i;
  logic [31:0] reported_size_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;
  logic        valid_o;
  logic [1:0]  kind_o;
  logic [15:0] out_log_id_o;
  logic [31:0] range_start_o;
  logic [31:0] range_end_o;
  logic        last_of_run_o;
  logic [31:0] received_frontier_o;

  ranged_download_gap_tracker_core #(
    .TABLE_ENTRIES(Entries),
    .RANGE_LIMIT  (MaxRanges)
  ) dut (.*);

  // Results the tracker still owes, oldest first.
  gap_result_t expected_results[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Shadow tracker state.
  logic [31:0] held_off[Entries];
  logic [15:0] held_len[Entries];
  int          held_n;
  logic [31:0] frontier, highest_end, file_size, frames_rx, count_at_req;
  logic        eof_seen, req_pending, round_done;
  logic [4:0]  ranges_exp, ranges_ans;
  logic [7:0]  stalled;
  logic [31:0] tick_ctr, req_tick;
  logic [15:0] active_log;
  mode_e       mode;
  logic [7:0]  idle_timeout, max_stalled;
  logic [4:0]  max_ranges;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Global watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("ranged_download_gap_tracker_core_tb NOT OK");
      $finish;
    end
  end

  // Compare each strobed result against the oldest prediction.
  always @(posedge clk_i) begin
    gap_result_t got, want;
    if (rst_ni && valid_o) begin
      got = '{kind_o, out_log_id_o, range_start_o, range_end_o, last_of_run_o,
              received_frontier_o};
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.kind != want.kind) begin
          error_count++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        end
        if (got.log_id != want.log_id) begin
          error_count++;
          $display("%0t: log id expected %h actual %h", $time, want.log_id, got.log_id);
        end
        if (got.rstart != want.rstart) begin
          error_count++;
          $display("%0t: range start expected %h actual %h", $time, want.rstart,
                   got.rstart);
        end
        if (got.rend != want.rend) begin
          error_count++;
          $display("%0t: range end expected %h actual %h", $time, want.rend, got.rend);
        end
        if (got.last != want.last) begin
          error_count++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        end
        if (got.frontier != want.frontier) begin
          error_count++;
          $display("%0t: frontier expected %h actual %h", $time, want.frontier,
                   got.frontier);
        end
      end
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_tracking();
    held_n = 0;
    frontier = '0; highest_end = '0; file_size = '0; frames_rx = '0;
    count_at_req = '1;
    eof_seen = 1'b0; req_pending = 1'b0; round_done = 1'b0;
    ranges_exp = '0; ranges_ans = '0; stalled = '0; req_tick = '0;
  endfunction

  function automatic void push_result(kind_e k, logic [31:0] s, logic [31:0] e,
                                      logic last);
    gap_result_t item;
    item = '{k, active_log, s, e, last, frontier};
    expected_results.insert(expected_results.size(), item);
  endfunction

  // Insert a frame in offset order, then retire entries the frontier covers.
  function automatic void insert_frame(logic [31:0] off, logic [15:0] len);
    int pos;
    pos = 0;
    if (len == 0 || off < frontier) return;
    while (pos < held_n && held_off[pos] < off) pos++;
    if (pos < held_n && held_off[pos] == off) return;
    if (held_n >= Entries) return;  // table full: drop, re-requested later
    for (int i = held_n; i > pos; i--) begin
      held_off[i] = held_off[i-1];
      held_len[i] = held_len[i-1];
    end
    held_off[pos] = off;
    held_len[pos] = len;
    held_n++;
    if (pos == held_n - 1) highest_end = off + 32'(len);
    if (frames_rx != '1) frames_rx++;
    while (held_n > 0 && held_off[0] <= frontier) begin
      if (held_off[0] == frontier) frontier = frontier + 32'(held_len[0]);
      for (int i = 0; i + 1 < held_n; i++) begin
        held_off[i] = held_off[i+1];
        held_len[i] = held_len[i+1];
      end
      held_n--;
    end
  endfunction

  function automatic void finish_download(logic ok);
    req_pending = 1'b0;
    mode = ok ? ModeIdle : ModeError;
    push_result(ok ? KindOk : KindError, '0, '0, 1'b1);
  endfunction

  // Round pacing: completion check, stall count, then the gap walk.
  function automatic void tick_round();
    logic        idle, contiguous, progressed;
    int unsigned limit, k;
    logic [31:0] cur, now;
    k = 0;
    tick_ctr++;
    if (mode != ModeLoad) return;
    now = tick_ctr;
    idle = (now - req_tick) >= 32'(idle_timeout);
    if (req_pending && !round_done && !idle) return;
    contiguous = (frontier == highest_end);
    progressed = !req_pending || frames_rx != count_at_req;
    if (eof_seen && contiguous && req_pending && !progressed) begin
      finish_download(1'b1);
      return;
    end
    if (file_size != 0 && frontier >= file_size && contiguous) begin
      finish_download(1'b1);
      return;
    end
    if (req_pending && !progressed) begin
      if (stalled != 8'hFF) stalled++;
      if (stalled >= max_stalled) begin
        finish_download(eof_seen && contiguous);
        return;
      end
    end else begin
      stalled = '0;
    end
    limit = max_ranges;
    if (limit < 1) limit = 1;
    if (limit > MaxRanges) limit = MaxRanges;
    cur = frontier;
    for (int i = 0; i < held_n && k < limit; i++) begin
      if (held_off[i] < cur) continue;
      if (held_off[i] > cur) begin
        push_result(KindRange, cur, held_off[i] + 32'(held_len[i]), 1'b0);
        k++;
      end
      cur = held_off[i] + 32'(held_len[i]);
    end
    if (k < limit && (file_size == 0 || cur < file_size)) begin
      push_result(KindRange, cur, TailEnd, 1'b0);
      k++;
    end
    if (k == 0) begin
      finish_download(contiguous);
      return;
    end
    count_at_req = frames_rx;
    ranges_ans = '0;
    ranges_exp = 5'(k);
    round_done = 1'b0;
    req_tick = now;
    req_pending = 1'b1;
    expected_results[$].last = 1'b1;
  endfunction

  function automatic void apply_event(logic [2:0] f, logic [15:0] id, logic [31:0] off,
                                      logic [15:0] len, logic [15:0] prob,
                                      logic [31:0] size);
    logic loading;
    loading = (mode == ModeLoad);
    case (f)
      FuncStart: begin
        if (loading && active_log != id) push_result(KindStop, '0, '0, 1'b1);
        clear_tracking();
        active_log = id;
        mode = ModeLoad;
      end
      FuncCancel: begin
        if (id == active_log) begin
          if (loading) push_result(KindStop, '0, '0, 1'b1);
          clear_tracking();
          mode = ModeIdle;
        end
      end
      FuncFrame: if (loading && id == active_log) insert_frame(off, len);
      FuncDiag: begin
        if (loading && id == active_log) begin
          if (size != 0) file_size = size;
          if (prob == ProblemTruncated || prob == ProblemInvalid) eof_seen = 1'b1;
          if (ranges_ans < 5'd31) ranges_ans++;
          if (ranges_ans >= ranges_exp) round_done = 1'b1;
        end
      end
      FuncTick: tick_round();
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------------ drivers

  // Hold the request until the block takes it; leave start high for a follow-on.
  task automatic send_event(logic [2:0] f, logic [15:0] id, logic [31:0] off = '0,
                            logic [15:0] len = '0, logic [15:0] prob = '0,
                            logic [31:0] size = '0);
    func_i <= f; log_id_i <= id; frame_offset_i <= off; frame_length_i <= len;
    problem_code_i <= prob; reported_size_i <= size;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    apply_event(f, id, off, len, prob, size);
  endtask

  // Drop start for a random gap: mostly none or short, a few long.
  task automatic sender_gap();
    int unsigned r, n;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n != 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Pause the sender until every owed result has come and the block is idle.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [7:0] data);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgIdleTimeout: idle_timeout = data;
      CfgMaxStalled:  max_stalled = data;
      default:        max_ranges = data[4:0];
    endcase
  endtask

  task automatic set_config(logic [7:0] idle, logic [7:0] stall, logic [7:0] ranges);
    drain();
    write_cfg(CfgIdleTimeout, idle);
    write_cfg(CfgMaxStalled, stall);
    write_cfg(CfgMaxRanges, ranges);
    cfg_we_i <= 1'b0;
  endtask

  // ------------------------------------------------------------------- tests

  // Directed: every event, field extremes and the special cases.
  task automatic test_directed();
    send_event(FuncTick, 16'h0000);                          // tick while idle
    send_event(FuncFrame, 16'h0000, 32'd0, 16'd10);          // frame while idle
    send_event(FuncStart, 16'h1234);
    send_event(FuncFrame, 16'h1234, 32'd0, 16'hFFFF);        // longest frame
    send_event(FuncFrame, 16'h1234, 32'd100, 16'd10);        // below frontier
    send_event(FuncFrame, 16'h1234, 32'h0002_0000, 16'd0);   // zero length
    send_event(FuncFrame, 16'h1234, 32'h0002_0000, 16'd16);
    send_event(FuncFrame, 16'h1234, 32'h0002_0000, 16'd32);  // duplicate offset
    send_event(FuncFrame, 16'hFFFF, 32'h0003_0000, 16'd16);  // other log
    send_event(FuncFrame, 16'h1234, 32'hFFFF_FFF0, 16'h0020);// end wraps
    send_event(3'd7, 16'h1234);                              // unknown code
    send_event(FuncTick, 16'h1234);                          // first round
    send_event(FuncCancel, 16'h0001);                        // other log: ignored
    send_event(FuncStart, 16'h1234);                         // same log restart
    send_event(FuncFrame, 16'h1234, 32'd0, 16'd100);
    send_event(FuncDiag, 16'h1234, '0, '0, ProblemTruncated, 32'hFFFF_FFFF);
    send_event(FuncDiag, 16'h1234, '0, '0, 16'hFFFF, 32'd100);
    send_event(FuncTick, 16'h1234);                          // finished ok
    send_event(FuncCancel, 16'h1234);                        // after finish
    send_event(FuncStart, 16'h0000);
    send_event(FuncTick, 16'h0000);
    send_event(FuncStart, 16'hFFFF);                         // preempt: stop
    send_event(FuncDiag, 16'hFFFF, '0, '0, ProblemInvalid, 32'd0);
    send_event(FuncCancel, 16'hFFFF);                        // stop on cancel
    send_event(3'd5, 16'h5555);
    send_event(3'd6, 16'hAAAA);
    drain();
  endtask

  // Overfill the table with disjoint frames so that late ones drop.
  task automatic test_table_full();
    send_event(FuncStart, 16'h00A5);
    for (int i = 0; i < Entries + 8; i++)
      send_event(FuncFrame, 16'h00A5, 32'(100 * (i + 1)), 16'd10);
    send_event(FuncTick, 16'h00A5);
    send_event(FuncFrame, 16'h00A5, 32'd0, 16'd100);         // retire at frontier
    for (int i = 0; i < 20; i++) send_event(FuncTick, 16'h00A5);
    send_event(FuncCancel, 16'h00A5);
  endtask

  // One download: start, then mostly in-file frames, diagnostics and ticks.
  task automatic random_download(int unsigned events);
    logic [15:0] id, len;
    logic [31:0] size, off;
    int unsigned chunk, r;
    id = 16'($urandom);
    chunk = $urandom_range(1, 64);
    size = 32'(chunk * $urandom_range(1, 40) - $urandom_range(0, chunk - 1));
    send_event(FuncStart, id);
    repeat (events) begin
      sender_gap();
      r = $urandom_range(0, 99);
      off = 32'(chunk * $urandom_range(0, size / chunk + 1));
      len = 16'(chunk);
      if (r < 50)
        send_event(FuncFrame, id, off, len);
      else if (r < 62)
        send_event(FuncDiag, id, '0, '0,
                   ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                   ($urandom_range(0, 1) ? ProblemTruncated : ProblemInvalid),
                   $urandom_range(0, 1) ? size : 32'd0);
      else if (r < 88)
        send_event(FuncTick, id);
      else if (r < 93)
        send_event(FuncFrame, $urandom_range(0, 1) ? id : 16'($urandom), $urandom,
                   16'($urandom));
      else if (r < 96)
        send_event(FuncDiag, id, $urandom, 16'($urandom), 16'($urandom), $urandom);
      else if (r < 98)
        send_event(3'($urandom_range(0, 7)), 16'($urandom), $urandom, 16'($urandom),
                   16'($urandom), $urandom);
      else
        send_event(FuncCancel, $urandom_range(0, 3) ? 16'($urandom) : id);
    end
  endtask

  // Random part over several settings, extremes first.
  task automatic test_random();
    set_config(8'd1, 8'd1, 8'd1);
    repeat (3) random_download(30);
    set_config(8'd255, 8'd255, 8'd16);
    repeat (3) random_download(30);
    set_config(8'd0, 8'd0, 8'd31);
    repeat (2) random_download(25);
    set_config(8'd2, 8'd3, 8'd2);
    repeat (3) random_download(30);
    set_config(8'($urandom_range(1, 12)), 8'($urandom_range(1, 10)),
               8'($urandom_range(1, 16)));
    repeat (3) random_download(30);
  endtask

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0; func_i <= '0; log_id_i <= '0; frame_offset_i <= '0;
    frame_length_i <= '0; problem_code_i <= '0; reported_size_i <= '0;
    cfg_we_i <= 1'b0; cfg_idx_i <= '0; cfg_data_i <= '0;
    clear_tracking();
    tick_ctr = '0; active_log = '0; mode = ModeIdle;
    idle_timeout = 8'd10; max_stalled = 8'd8; max_ranges = 5'd16;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_table_full();
    test_random();
    drain();

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ranged_download_gap_tracker_core_tb OK");
    end else begin
      $display("ranged_download_gap_tracker_core_tb NOT OK");
    end
    $finish;
  end

endmodule
